// ===== hw/rtl/ets_pkg.sv =====
// Shared constants, types and a helper function for the epoch seconds to calendar block.
package ets_pkg;

    localparam int unsigned EpochYear = 1970;

    // Reciprocal constants for exact division by a multiply and shift.
    // The day divide works on seconds/128, so the divisor there is 86400/128 = 675.
    localparam logic [26:0] DayRecip  = 27'd101806633;   // ceil(2^36 / 675)
    localparam int unsigned DayShift  = 36;
    localparam logic [11:0] YearRecip = 12'd2871;        // about 2^20 / 365.25
    localparam int unsigned YearShift = 20;
    localparam logic [17:0] HourRecip = 18'd149131;      // ceil(2^29 / 3600)
    localparam int unsigned HourShift = 29;
    localparam logic [12:0] MinRecip  = 13'd4370;        // ceil(2^18 / 60)
    localparam int unsigned MinShift  = 18;

    localparam logic [31:0] SecsPerDay  = 32'd86400;
    localparam logic [16:0] SecsPerHour = 17'd3600;
    localparam logic [11:0] SecsPerMin  = 12'd60;

    // Year 2100 is the only century year in range, and it is not a leap year.
    localparam logic [7:0] FirstIdxAfter2100 = 8'd131;

    typedef logic [15:0] day_count_t;
    typedef logic [7:0]  year_idx_t;

    // Day number, counted from 1970-01-01, of January 1 of year 1970 + idx.
    function automatic day_count_t year_start(input year_idx_t idx);
        logic [8:0]  idx_p1;
        day_count_t  base;
        day_count_t  leaps;
        begin
            idx_p1 = {1'b0, idx} + 9'd1;
            base   = 16'(16'd365 * {8'd0, idx});
            leaps  = {9'd0, idx_p1[8:2]};
            if (idx >= FirstIdxAfter2100)
            begin
                leaps = leaps - 16'd1;
            end
            year_start = base + leaps;
        end
    endfunction

endpackage

// ===== hw/rtl/ets_in_if.sv =====
// Input channel interface: one epoch timestamp per transaction.
interface ets_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== hw/rtl/ets_out_if.sv =====
// Output channel interface: one calendar result per transaction.
interface ets_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output day_of_year, output hour,
                    output minute, output second, input ready);
    modport sink   (input valid, input year, input day_of_year, input hour,
                    input minute, input second, output ready);
endinterface

// ===== hw/rtl/ets_core.sv =====
// Six-stage datapath that turns epoch seconds into year, day of year and time of day.
module ets_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        valid_in,
    input  logic [31:0] epoch_seconds,
    output logic        valid_out,
    output logic [11:0] year,
    output logic [8:0]  day_of_year,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    // Stage 1: whole days.
    logic [31:0] s1_secs_reg;
    logic [15:0] s1_days_reg;
    logic [51:0] s1_prod;
    // Stage 2: seconds of day and a year estimate.
    logic [16:0] s2_sod_reg;
    logic [15:0] s2_days_reg;
    logic [7:0]  s2_est_reg;
    logic [31:0] s2_day_secs;
    logic [31:0] s2_sod_full;
    logic [27:0] s2_est_prod;
    // Stage 3: year fixed up, hour.
    logic [7:0]  s3_idx_reg;
    logic [8:0]  s3_doy_reg;
    logic [4:0]  s3_hour_reg;
    logic [16:0] s3_sod_reg;
    logic [7:0]  s3_idx;
    logic [15:0] s3_start_lo;
    logic [15:0] s3_start_hi;
    logic [15:0] s3_start;
    logic [15:0] s3_doy_full;
    logic [34:0] s3_hour_prod;
    // Stage 4: seconds of hour.
    logic [7:0]  s4_idx_reg;
    logic [8:0]  s4_doy_reg;
    logic [4:0]  s4_hour_reg;
    logic [11:0] s4_soh_reg;
    logic [16:0] s4_soh_full;
    // Stage 5: minute.
    logic [7:0]  s5_idx_reg;
    logic [8:0]  s5_doy_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_soh_reg;
    logic [5:0]  s5_min_reg;
    logic [24:0] s5_min_prod;
    // Stage 6: second and output register.
    logic [11:0] s6_year_reg;
    logic [8:0]  s6_doy_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    logic [5:0]  s6_sec_reg;
    logic [11:0] s6_sec_full;

    assign vld_next = {vld_reg[4:0], valid_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        s1_prod     = {27'd0, epoch_seconds[31:7]} * {25'd0, ets_pkg::DayRecip};
        s2_day_secs = 32'({16'd0, s1_days_reg} * ets_pkg::SecsPerDay);
        s2_sod_full = s1_secs_reg - s2_day_secs;
        s2_est_prod = {12'd0, s1_days_reg} * {16'd0, ets_pkg::YearRecip};

        // The estimate is within one year of the truth; three table looks settle it.
        s3_start_lo = ets_pkg::year_start(s2_est_reg);
        s3_start_hi = ets_pkg::year_start(s2_est_reg + 8'd1);
        if (s3_start_lo > s2_days_reg)
        begin
            s3_idx   = s2_est_reg - 8'd1;
            s3_start = ets_pkg::year_start(s2_est_reg - 8'd1);
        end
        else if (s3_start_hi <= s2_days_reg)
        begin
            s3_idx   = s2_est_reg + 8'd1;
            s3_start = s3_start_hi;
        end
        else
        begin
            s3_idx   = s2_est_reg;
            s3_start = s3_start_lo;
        end
        s3_doy_full  = s2_days_reg - s3_start + 16'd1;
        s3_hour_prod = {18'd0, s2_sod_reg} * {17'd0, ets_pkg::HourRecip};

        s4_soh_full = s3_sod_reg - 17'({12'd0, s3_hour_reg} * ets_pkg::SecsPerHour);
        s5_min_prod = {13'd0, s4_soh_reg} * {12'd0, ets_pkg::MinRecip};
        s6_sec_full = s5_soh_reg - 12'({6'd0, s5_min_reg} * ets_pkg::SecsPerMin);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_secs_reg <= epoch_seconds;
            s1_days_reg <= s1_prod[ets_pkg::DayShift +: 16];

            s2_sod_reg  <= s2_sod_full[16:0];
            s2_days_reg <= s1_days_reg;
            s2_est_reg  <= s2_est_prod[ets_pkg::YearShift +: 8];

            s3_idx_reg  <= s3_idx;
            s3_doy_reg  <= s3_doy_full[8:0];
            s3_hour_reg <= s3_hour_prod[ets_pkg::HourShift +: 5];
            s3_sod_reg  <= s2_sod_reg;

            s4_idx_reg  <= s3_idx_reg;
            s4_doy_reg  <= s3_doy_reg;
            s4_hour_reg <= s3_hour_reg;
            s4_soh_reg  <= s4_soh_full[11:0];

            s5_idx_reg  <= s4_idx_reg;
            s5_doy_reg  <= s4_doy_reg;
            s5_hour_reg <= s4_hour_reg;
            s5_soh_reg  <= s4_soh_reg;
            s5_min_reg  <= s5_min_prod[ets_pkg::MinShift +: 6];

            s6_year_reg <= 12'(ets_pkg::EpochYear) + {4'd0, s5_idx_reg};
            s6_doy_reg  <= s5_doy_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_min_reg  <= s5_min_reg;
            s6_sec_reg  <= s6_sec_full[5:0];
        end
    end

    assign valid_out   = vld_reg[5];
    assign year        = s6_year_reg;
    assign day_of_year = s6_doy_reg;
    assign hour        = s6_hour_reg;
    assign minute      = s6_min_reg;
    assign second      = s6_sec_reg;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch seconds to calendar converter.
// Converts whole seconds since 1970-01-01 00:00:00 UTC into year, day of year,
// hour, minute and second. The block is a six-stage pipeline: one transaction
// is accepted every cycle unless the output stalls; the divides by 86400,
// 3600 and 60 are reciprocal multiplies, each followed by a register, and
// the year comes from an estimate fixed up against a year-start table.
// When the output is stalled the whole pipeline holds, so nothing is lost.
module epoch_seconds_to_calendar (
    input  logic   clk,
    input  logic   rst_n,
    ets_in_if.sink   in_ch,
    ets_out_if.source out_ch
);

    logic advance;

    // The pipeline moves when its last stage is empty or being drained.
    assign advance     = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;

    ets_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .valid_in      (in_ch.valid),
        .epoch_seconds (in_ch.epoch_seconds),
        .valid_out     (out_ch.valid),
        .year          (out_ch.year),
        .day_of_year   (out_ch.day_of_year),
        .hour          (out_ch.hour),
        .minute        (out_ch.minute),
        .second        (out_ch.second)
    );

endmodule
